// ===== rtl/core/nfkst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfkst_pkg
// Shared types and constants for the next-fit key slot table.
// ----------------------------------------------------------------------------
package nfkst_pkg;

    // Default table geometry
    localparam int NUM_SLOTS_DEF  = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed port field widths
    localparam int KIND_W    = 2;
    localparam int KEY_W     = 8;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int NEW_KEY_W = 6;

    // Request opcodes
    typedef enum logic [KIND_W-1:0] {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_SET    = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADKEY = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // Control sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

// ===== rtl/core/next_fit_key_slot_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_key_slot_table_unit
// Key slot table with next-fit allocation: create, delete, get and set.
// ----------------------------------------------------------------------------
// Busy is high in the cycle after start is taken, and o_done pulses for one
// cycle with the result in the cycle after that, during which the next
// request may already be issued. The value RAM's registered read, issued
// when start is taken, is followed by the read-modify-write state, in which
// a create's rotating free-slot search over the used-bit vector runs. Results
// are shown for exactly one cycle and cannot be held off; the receiver must
// capture them when o_done is high.
// Values in slots that were never written are never visible, since create
// clears the slot it hands out. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module next_fit_key_slot_table_unit #(
    parameter int NUM_SLOTS  = nfkst_pkg::NUM_SLOTS_DEF,
    parameter int VALUE_BITS = nfkst_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [nfkst_pkg::KIND_W-1:0]   i_kind,
    input  logic [nfkst_pkg::KEY_W-1:0]    i_key,
    input  logic [nfkst_pkg::VALUE_W-1:0]  i_value,
    output logic                           o_done,
    output logic [nfkst_pkg::STATUS_W-1:0] o_status,
    output logic [nfkst_pkg::NEW_KEY_W-1:0] o_new_key,
    output logic [nfkst_pkg::VALUE_W-1:0]  o_read_value
);

    import nfkst_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    // Control state
    t_state                r_state, n_state;
    logic [NUM_SLOTS-1:0]  r_used, n_used;
    logic [SLOT_W-1:0]     r_search_start, n_search_start;
    logic                  r_done, n_done;

    // Captured request
    t_op                   r_kind;
    logic [SLOT_W-1:0]     r_idx;
    logic                  r_key_ok;
    logic [VALUE_BITS-1:0] r_value;

    // Result registers
    t_status               r_status, n_status;
    logic [NEW_KEY_W-1:0]  r_new_key, n_new_key;
    logic [VALUE_W-1:0]    r_read_value, n_read_value;

    // RAM port signals
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [VALUE_BITS-1:0] ram_rdata;

    // Search results
    logic [NUM_SLOTS-1:0]  free_vec;
    logic [NUM_SLOTS-1:0]  upper_free;
    logic [NUM_SLOTS-1:0]  pick_vec;
    logic [NUM_SLOTS-1:0]  pick_onehot;
    logic [SLOT_W-1:0]     find_idx;
    logic                  free_any;
    logic [SLOT_W-1:0]     next_start;
    logic                  key_valid;

    logic                  accept;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state == S_EXEC);

    // Value storage; read issued at accept, data ready in the exec cycle
    nfkst_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (SLOT_W'(i_key)),
        .o_rdata (ram_rdata)
    );

    // Rotated next-fit search: first free slot at or above the pointer,
    // otherwise the lowest free slot overall
    always_comb begin
        free_vec = ~r_used;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            upper_free[i] = free_vec[i] && (SLOT_W'(i) >= r_search_start);
        end
        pick_vec    = (upper_free != '0) ? upper_free : free_vec;
        pick_onehot = pick_vec & (~pick_vec + NUM_SLOTS'(1));
        find_idx    = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (pick_onehot[i]) begin
                find_idx = find_idx | SLOT_W'(i);
            end
        end
        free_any   = (free_vec != '0);
        next_start = (find_idx == SLOT_W'(NUM_SLOTS - 1)) ? '0 : find_idx + SLOT_W'(1);
    end

    // Key must be in range and in use
    assign key_valid = r_key_ok ? r_used[r_idx] : 1'b0;

    // Next state and read-modify-write
    always_comb begin
        n_state        = r_state;
        n_used         = r_used;
        n_search_start = r_search_start;
        n_done         = 1'b0;
        n_status       = ST_OK;
        n_new_key      = '0;
        n_read_value   = '0;
        ram_we         = 1'b0;
        ram_waddr      = r_idx;
        ram_wdata      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (r_kind == OP_CREATE) begin
                    if (free_any) begin
                        n_used[find_idx] = 1'b1;
                        ram_we           = 1'b1;
                        ram_waddr        = find_idx;
                        n_search_start   = next_start;
                        n_new_key        = NEW_KEY_W'(find_idx);
                    end else begin
                        n_status = ST_FULL;
                    end
                end else if (!key_valid) begin
                    n_status = ST_BADKEY;
                end else begin
                    unique case (r_kind)
                        OP_DELETE: begin
                            n_used[r_idx] = 1'b0;
                            ram_we        = 1'b1;
                        end
                        OP_GET: begin
                            n_read_value = VALUE_W'(ram_rdata);
                        end
                        OP_SET: begin
                            ram_we    = 1'b1;
                            ram_wdata = r_value;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_used         <= '0;
            r_search_start <= '0;
            r_done         <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_used         <= n_used;
            r_search_start <= n_search_start;
            r_done         <= n_done;
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= t_op'(i_kind);
            r_idx    <= SLOT_W'(i_key);
            r_key_ok <= (32'(i_key) < 32'(NUM_SLOTS));
            r_value  <= VALUE_BITS'(i_value);
        end
    end

    // Result beat registers
    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_new_key    <= n_new_key;
        r_read_value <= n_read_value;
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_new_key    = r_new_key;
    assign o_read_value = r_read_value;

endmodule

// ===== rtl/core/nfkst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfkst_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module nfkst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
